// File: rtl/fir_linear_convolution_macros.svh
// ----------------------------------------------------------------------------
// fir_linear_convolution assertion macros
// Shared concurrent assertion forms for the convolution block.
// ----------------------------------------------------------------------------
`ifndef FIR_LINEAR_CONVOLUTION_MACROS_SVH
`define FIR_LINEAR_CONVOLUTION_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("flc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("flc assertion failed");

`endif

// File: rtl/flc_pkg.sv
// ----------------------------------------------------------------------------
// flc_pkg
// Widths, command codes and the cell control bundle of the convolution block.
// ----------------------------------------------------------------------------
package flc_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int ACC_W  = 40;
    localparam int IDX_W  = 5;
    localparam int CFG_W  = 6;

    localparam logic [CFG_W-1:0] TAP_COUNT_RESET = 6'd32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic                     shift;
        logic                     clear;
        logic signed [DATA_W-1:0] sample;
        logic                     coef_we;
        logic [IDX_W-1:0]         coef_idx;
        logic signed [DATA_W-1:0] coef_data;
    } cell_ctl_t;

endpackage

// File: rtl/flc_cell.sv
// ----------------------------------------------------------------------------
// flc_cell
// One tap: coefficient, delay line stage, product and partial sum stage.
// ----------------------------------------------------------------------------
module flc_cell
    import flc_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  cell_ctl_t                ctl,
    input  logic                     coef_wr,
    input  logic                     tap_en,
    input  logic signed [DATA_W-1:0] samp_in,
    output logic signed [DATA_W-1:0] samp_out,
    input  logic signed [ACC_W-1:0]  acc_in,
    output logic signed [ACC_W-1:0]  acc_out
);

    logic signed [DATA_W-1:0] coef_reg;
    logic signed [DATA_W-1:0] samp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    always_ff @(posedge aclk) begin
        if (coef_wr) begin
            coef_reg <= ctl.coef_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samp_reg <= '0;
        end else if (ctl.clear) begin
            samp_reg <= '0;
        end else if (ctl.shift) begin
            samp_reg <= samp_in;
        end
    end

    // product follows the held tap and sample; stable during a pass
    always_ff @(posedge aclk) begin
        prod_reg <= coef_reg * samp_reg;
    end

    // taps beyond the count in use pass the partial sum through
    always_comb begin
        acc_next = acc_in;
        if (tap_en) begin
            acc_next = acc_in + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign samp_out = samp_reg;
    assign acc_out  = acc_reg;

endmodule

// File: rtl/flc_ctrl.sv
// ----------------------------------------------------------------------------
// flc_ctrl
// Handshakes, tap count register, pass sequencing and the output register.
// ----------------------------------------------------------------------------
`include "fir_linear_convolution_macros.svh"

module flc_ctrl
    import flc_pkg::*;
#(
    parameter int MAX_TAPS = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [IDX_W-1:0]               s_tap_index,
    input  logic signed [DATA_W-1:0]       s_data_value,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [ACC_W-1:0]        m_out_value,
    output logic                           m_end_of_signal,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [CFG_W-1:0]               cfg_tap_count,
    output cell_ctl_t                      ctl,
    output logic [$clog2(MAX_TAPS+1)-1:0]  t_eff,
    input  logic signed [ACC_W-1:0]        acc_sel
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int CW = $clog2(MAX_TAPS + 3);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         tc_reg;
    logic [CW-1:0]            cnt_reg, cnt_next;
    logic [TW-1:0]            tail_left_reg, tail_left_next;
    logic                     flush_reg, flush_next;
    logic signed [ACC_W-1:0]  res_reg;
    logic                     res_end_reg;
    logic                     m_valid_reg, m_valid_next;
    logic signed [ACC_W-1:0]  m_out_value_reg;
    logic                     m_end_reg;

    logic s_xfer;
    logic out_free;
    logic pass_hit;
    logic load_out;
    logic more_tail;

    // tap count in use: zero acts as one, large values saturate
    always_comb begin
        if (tc_reg == '0) begin
            t_eff = TW'(1);
        end else if (int'(tc_reg) > MAX_TAPS) begin
            t_eff = TW'(MAX_TAPS);
        end else begin
            t_eff = TW'(tc_reg);
        end
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tc_reg <= TAP_COUNT_RESET;
        end else if (cfg_valid) begin
            tc_reg <= cfg_tap_count;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    // the pass ends once the sum of the last tap in use has settled
    assign pass_hit  = (state_reg == ST_RUN) && (cnt_reg == CW'(t_eff) + CW'(1));
    assign load_out  = (state_reg == ST_DONE) && out_free;
    assign more_tail = flush_reg && (tail_left_reg != '0);

    always_comb begin
        ctl           = '0;
        ctl.coef_we   = s_xfer && (s_cmd == CMD_LOAD);
        ctl.coef_idx  = s_tap_index;
        ctl.coef_data = s_data_value;
        ctl.sample    = s_xfer ? s_data_value : '0;
        ctl.shift     = (s_xfer && (s_cmd == CMD_SAMPLE)) || (load_out && more_tail);
        ctl.clear     = load_out && flush_reg && !more_tail;
    end

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        tail_left_next = tail_left_reg;
        flush_next     = flush_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_xfer && (s_cmd == CMD_SAMPLE)) begin
                    state_next     = ST_RUN;
                    cnt_next       = '0;
                    flush_next     = s_last_sample;
                    tail_left_next = s_last_sample ? (t_eff - TW'(1)) : '0;
                end
            end
            ST_RUN: begin
                if (pass_hit) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (more_tail) begin
                        state_next     = ST_RUN;
                        cnt_next       = '0;
                        tail_left_next = tail_left_reg - TW'(1);
                    end else begin
                        state_next = ST_IDLE;
                        flush_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            tail_left_reg <= '0;
            flush_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            tail_left_reg <= tail_left_next;
            flush_reg     <= flush_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pass_hit) begin
            res_reg     <= acc_sel;
            res_end_reg <= flush_reg && (tail_left_reg == '0);
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_out_value_reg <= res_reg;
            m_end_reg       <= res_end_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_out_value     = m_out_value_reg;
    assign m_end_of_signal = m_end_reg;

    `FLC_ASSERT_NOW(a_cnt_bound, aclk, aresetn, state_reg == ST_RUN, cnt_reg <= CW'(t_eff) + CW'(1))
    `FLC_ASSERT_NOW(a_idle_no_tail, aclk, aresetn, state_reg == ST_IDLE, tail_left_reg == '0 && !flush_reg)
    `FLC_ASSERT_NEXT(a_load_out, aclk, aresetn, load_out, m_valid_reg && m_out_value_reg == $past(res_reg))
    `FLC_ASSERT_NEXT(a_tail_restart, aclk, aresetn, load_out && more_tail, state_reg == ST_RUN && cnt_reg == '0)

endmodule

// File: rtl/fir_linear_convolution.sv
// ----------------------------------------------------------------------------
// fir_linear_convolution
// Full linear convolution of a sample stream with a loaded impulse response.
// ----------------------------------------------------------------------------
// Input channel (s_valid/s_ready): s_cmd selects a coefficient load (written
// to tap s_tap_index, no result) or a sample. Each sample shifts into a
// chain of MAX_TAPS cells, each holding one tap, one delay stage and one
// partial sum stage; the partial sum walks down the chain one cell per
// cycle. The sum over the t taps in use goes through the result register
// to the output register, and only then is the next item taken.
// A sample with s_last_sample also gives t-1 tail results, each from its own
// pass, the final one flagged by m_end_of_signal; the delay line then
// clears. Config channel (cfg_valid/cfg_ready, always ready) writes the tap
// count. Reset clears the delay line and sets the tap count to 32; taps are
// undefined until loaded. A stalled receiver holds the result in the output
// register; the next pass still runs and waits for that register to free.
// ----------------------------------------------------------------------------
module fir_linear_convolution
    import flc_pkg::*;
#(
    parameter int MAX_TAPS = 32
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic [IDX_W-1:0]         s_tap_index,
    input  logic signed [DATA_W-1:0] s_data_value,
    input  logic                     s_last_sample,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [ACC_W-1:0]  m_out_value,
    output logic                     m_end_of_signal,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_W-1:0]         cfg_tap_count
);

    localparam int TW = $clog2(MAX_TAPS + 1);
    localparam int IW = $clog2(MAX_TAPS);

    cell_ctl_t                ctl;
    logic [TW-1:0]            t_eff;
    logic [TW-1:0]            t_last;
    logic signed [ACC_W-1:0]  acc_sel;
    logic signed [DATA_W-1:0] samp_chain [MAX_TAPS];
    logic signed [ACC_W-1:0]  acc_chain  [MAX_TAPS];

    flc_ctrl #(
        .MAX_TAPS (MAX_TAPS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_tap_index     (s_tap_index),
        .s_data_value    (s_data_value),
        .s_last_sample   (s_last_sample),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_value     (m_out_value),
        .m_end_of_signal (m_end_of_signal),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_tap_count   (cfg_tap_count),
        .ctl             (ctl),
        .t_eff           (t_eff),
        .acc_sel         (acc_sel)
    );

    for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
        logic signed [DATA_W-1:0] samp_link;
        logic signed [ACC_W-1:0]  acc_link;

        if (j == 0) begin : g_head
            assign samp_link = ctl.sample;
            assign acc_link  = '0;
        end else begin : g_body
            assign samp_link = samp_chain[j-1];
            assign acc_link  = acc_chain[j-1];
        end

        flc_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .coef_wr  (ctl.coef_we && (int'(ctl.coef_idx) == j)),
            .tap_en   (j < int'(t_eff)),
            .samp_in  (samp_link),
            .samp_out (samp_chain[j]),
            .acc_in   (acc_link),
            .acc_out  (acc_chain[j])
        );
    end

    // result is taken at the last cell in use
    assign t_last  = t_eff - TW'(1);
    assign acc_sel = acc_chain[t_last[IW-1:0]];

endmodule
